### src/dft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types, constants and helpers for the display frame translator.
// ----------------------------------------------------------------------------

package dft_pkg;

  localparam logic [7:0]  FrameHead   = 8'h80;
  localparam logic [6:0]  DigitBlank  = 7'h7f;
  localparam logic [6:0]  LogoFlag    = 7'h40;
  localparam logic [6:0]  InspectFlag = 7'h08;
  localparam logic [14:0] FloorNone   = 15'h7fff;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FB_NONE    = 2'd0,
    FB_FLOOR   = 2'd1,
    FB_INSPECT = 2'd2,
    FB_ZERO    = 2'd3
  } fb_mode_e;

  typedef enum logic [1:0] {
    CFG_COINCIDE  = 2'd0,
    CFG_DOOR_SND  = 2'd1,
    CFG_FB_MODE   = 2'd2,
    CFG_FB_PERIOD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] header_byte;
    logic [7:0] status_byte;
    logic [7:0] tens_byte;
    logic [7:0] units_byte;
    logic [7:0] motion_byte;
    logic [7:0] alarm_byte;
    logic [7:0] service_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] hundreds_digit;
    logic [6:0] tens_digit;
    logic [6:0] units_digit;
    logic [4:0] basic_functions;
    logic [6:0] function_one;
    logic [6:0] function_two;
    logic [1:0] function_three;
    logic [6:0] check_byte;
  } out_word_t;

  typedef struct packed {
    logic        coincide_mode;
    logic        door_open_sound;
    fb_mode_e    fallback_mode;
    logic [15:0] fallback_period;
  } cfg_t;

  // frame decode status toward the top level
  typedef struct packed {
    logic        head_ok;
    logic [14:0] floor_now;
    logic [15:0] func_now;
  } xlate_stat_t;

  function automatic out_word_t build_word(logic [6:0] h, logic [6:0] t, logic [6:0] u,
                                           logic [4:0] b, logic [6:0] f1, logic [6:0] f2,
                                           logic [1:0] f3);
    out_word_t w;
    w.hundreds_digit  = h;
    w.tens_digit      = t;
    w.units_digit     = u;
    w.basic_functions = b;
    w.function_one    = f1;
    w.function_two    = f2;
    w.function_three  = f3;
    w.check_byte      = h ^ t ^ u ^ {2'b00, b} ^ f1 ^ f2 ^ {5'b00000, f3};
    return w;
  endfunction

endpackage

### src/dft_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_xlate
// Maps one controller status frame onto a display word, with coincide-mode
// suppression and blanking against the last floor and function values.
// ----------------------------------------------------------------------------

module dft_xlate (
  input  dft_pkg::in_word_t    word_i,
  input  dft_pkg::cfg_t        cfg_i,
  input  logic [14:0]          last_floor_i,
  input  logic [15:0]          last_func_i,
  output dft_pkg::out_word_t   word_o,
  output dft_pkg::xlate_stat_t stat_o
);

  logic        moved;
  logic        arrive, run, down, up, door_open, door_close, talk, blank;
  logic [6:0]  f1, f2, tens, units;
  logic [1:0]  f3;
  logic [4:0]  basic;
  logic [14:0] floor_now;
  logic [15:0] func_now;

  always_comb begin
    tens      = word_i.tens_byte[6:0];
    units     = word_i.units_byte[6:0];
    floor_now = {tens, 1'b0, units};
    moved     = (floor_now != last_floor_i) && cfg_i.coincide_mode;

    arrive    = word_i.motion_byte[0];
    run       = word_i.motion_byte[1];
    down      = ~word_i.motion_byte[2];
    up        = ~word_i.motion_byte[3];
    door_open = cfg_i.door_open_sound & arrive;
    talk      = moved & word_i.service_byte[6];
    basic     = {talk, arrive, run, down, up};

    door_close = 1'b0;
    f1         = '0;
    f2         = '0;
    f3         = '0;
    if (!moved) begin
      door_close = word_i.status_byte[5];
      f1 = {word_i.alarm_byte[3], word_i.alarm_byte[2], word_i.motion_byte[6],
            word_i.alarm_byte[4], word_i.status_byte[1], word_i.status_byte[0],
            word_i.motion_byte[4]};
      f2 = {1'b0, word_i.alarm_byte[0], 1'b0, word_i.motion_byte[5],
            word_i.alarm_byte[5], word_i.service_byte[3], word_i.service_byte[0]};
      f3 = {door_open, door_close};
    end

    func_now = {f3, f2, f1};
    blank    = (func_now != last_func_i) && cfg_i.coincide_mode && !moved
               && !(door_close || door_open);

    word_o = dft_pkg::build_word(blank ? dft_pkg::DigitBlank : 7'd0,
                                 blank ? dft_pkg::DigitBlank : tens,
                                 blank ? dft_pkg::DigitBlank : units,
                                 basic, f1, f2, f3);

    stat_o.head_ok   = (word_i.header_byte == dft_pkg::FrameHead);
    stat_o.floor_now = floor_now;
    stat_o.func_now  = func_now;
  end

endmodule

### src/display_frame_translator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_translator_top
// Frame and tick intake, fallback timer, and a two-word output buffer.
// ----------------------------------------------------------------------------
// Results are registered in the output buffer before they reach out_word_o.
// Throughput: one word per cycle; input stalls only when both output slots
// are full.
// Reset: config zero, last floor none, last function zero, timer stopped,
// output buffer empty.

module display_frame_translator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dft_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dft_pkg::out_word_t out_word_o
);

  dft_pkg::cfg_t        cfg_q;
  dft_pkg::out_word_t   xl_word, res_word, buf0_q, buf0_d, buf1_q, buf1_d;
  dft_pkg::xlate_stat_t xl_stat;

  logic [14:0] last_floor_q, last_floor_d;
  logic [15:0] last_func_q, last_func_d;
  logic        phase_q, phase_d, running_q, running_d;
  logic [15:0] elapsed_q, elapsed_d, elapsed_inc, limit;
  logic        v0_q, v0_d, v1_q, v1_d;
  logic        accept, res_valid, push, pop, fire, next_phase;
  logic [6:0]  t_t, t_u, t_f1, t_f2;

  dft_xlate u_xlate (
    .word_i       (in_word_i),
    .cfg_i        (cfg_q),
    .last_floor_i (last_floor_q),
    .last_func_i  (last_func_q),
    .word_o       (xl_word),
    .stat_o       (xl_stat)
  );

  assign in_ready_o  = ~v1_q;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = v0_q;
  assign out_word_o  = buf0_q;

  always_comb begin
    last_floor_d = last_floor_q;
    last_func_d  = last_func_q;
    phase_d      = phase_q;
    running_d    = running_q;
    elapsed_d    = elapsed_q;
    res_valid    = 1'b0;
    res_word     = xl_word;

    limit       = (cfg_q.fallback_period == 16'd0) ? 16'd1 : cfg_q.fallback_period;
    elapsed_inc = elapsed_q + 16'd1;
    fire        = running_q && (elapsed_inc >= limit);
    next_phase  = ~phase_q;

    t_t  = '0;
    t_u  = '0;
    t_f1 = '0;
    t_f2 = '0;
    case (cfg_q.fallback_mode)
      dft_pkg::FB_FLOOR: begin
        if (next_phase) begin
          t_f2 = dft_pkg::LogoFlag;
        end else begin
          t_t = last_floor_q[14:8];
          t_u = last_floor_q[6:0];
        end
      end
      dft_pkg::FB_INSPECT: begin
        if (next_phase) begin
          t_f1 = dft_pkg::InspectFlag;
        end else begin
          t_f2 = dft_pkg::LogoFlag;
        end
      end
      default: ;
    endcase

    if (in_word_i.operation == dft_pkg::OP_TICK) begin
      if (running_q) begin
        elapsed_d = fire ? 16'd0 : elapsed_inc;
        if (fire) begin
          if (cfg_q.fallback_mode == dft_pkg::FB_NONE) begin
            phase_d   = 1'b0;
            running_d = 1'b0;
          end else begin
            phase_d   = next_phase;
            res_valid = 1'b1;
            res_word  = dft_pkg::build_word(7'd0, t_t, t_u, 5'd0, t_f1, t_f2, 2'd0);
          end
        end
      end
    end else if (xl_stat.head_ok) begin
      res_valid    = 1'b1;
      last_floor_d = xl_stat.floor_now;
      last_func_d  = xl_stat.func_now;
      if (cfg_q.fallback_mode != dft_pkg::FB_NONE) begin
        phase_d   = 1'b0;
        running_d = 1'b1;
        elapsed_d = 16'd0;
      end
    end
  end

  // two-slot output buffer
  assign push = accept & res_valid;
  assign pop  = v0_q & out_ready_i;

  always_comb begin
    v0_d   = v0_q;
    v1_d   = v1_q;
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    case ({push, pop})
      2'b10: begin
        if (!v0_q) begin
          v0_d   = 1'b1;
          buf0_d = res_word;
        end else begin
          v1_d   = 1'b1;
          buf1_d = res_word;
        end
      end
      2'b01: begin
        buf0_d = buf1_q;
        v0_d   = v1_q;
        v1_d   = 1'b0;
      end
      2'b11: begin
        if (v1_q) begin
          buf0_d = buf1_q;
          buf1_d = res_word;
        end else begin
          buf0_d = res_word;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      last_floor_q <= dft_pkg::FloorNone;
      last_func_q  <= '0;
      phase_q      <= 1'b0;
      running_q    <= 1'b0;
      elapsed_q    <= '0;
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dft_pkg::cfg_idx_e'(cfg_index_i))
          dft_pkg::CFG_COINCIDE:  cfg_q.coincide_mode   <= cfg_data_i[0];
          dft_pkg::CFG_DOOR_SND:  cfg_q.door_open_sound <= cfg_data_i[0];
          dft_pkg::CFG_FB_MODE:   cfg_q.fallback_mode   <= dft_pkg::fb_mode_e'(cfg_data_i[1:0]);
          dft_pkg::CFG_FB_PERIOD: cfg_q.fallback_period <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        last_floor_q <= last_floor_d;
        last_func_q  <= last_func_d;
        phase_q      <= phase_d;
        running_q    <= running_d;
        elapsed_q    <= elapsed_d;
      end
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

endmodule
